[rtl/rgp_pkg.sv]
`default_nettype none

package rgp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int EPSILON    = 1;

    // floored product width: 64-bit product with the fraction bits dropped
    localparam int PROD_W     = 64 - FRAC_BITS;

    // front-to-back queue
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    // square root: one result bit per step, 64-bit radicand
    localparam int SQRT_STEPS = 32;
    localparam int SQ_REM_W   = 35;

    // divider: 33 quotient bits, anything larger saturates
    localparam int DIV_STEPS  = 33;
    localparam int DIVW       = 34;
    localparam int DREM_W     = DIVW + FRAC_BITS;
    localparam int DTRIAL_W   = DIVW + DIV_STEPS - 1;

    localparam logic [3:0] REG_CENTER_XY    = 4'd0;
    localparam logic [3:0] REG_START_RADIUS = 4'd1;
    localparam logic [3:0] REG_DELTA_X      = 4'd2;
    localparam logic [3:0] REG_DELTA_Y      = 4'd3;
    localparam logic [3:0] REG_DELTA_RADIUS = 4'd4;
    localparam logic [3:0] REG_T_START      = 4'd5;
    localparam logic [3:0] REG_T_END        = 4'd6;
    localparam logic [3:0] REG_EXTEND_MODE  = 4'd7;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] SAT_HI  = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO  = -64'sh0000_0000_8000_0000;
    localparam logic signed [31:0] EPS_Q   = 32'(EPSILON);
    localparam logic signed [32:0] ONE_Q   = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] T_END_RESET = 32'sd65536;

    typedef struct packed {
        logic signed [31:0] pixel_x;
        logic signed [31:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic               valid_res;
        logic signed [31:0] t_value;
    } result_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic        [30:0] start_radius;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_radius;
        logic signed [31:0] t_start;
        logic signed [31:0] t_end;
        logic        [1:0]  extend_mode;
        logic signed [31:0] quad;
        logic signed [32:0] t_span;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic               dead;   // no root can qualify
        logic               lin;    // linear case
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [PROD_W-1:0]  disc;   // discriminant, zero when unused
    } job_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = S32_MAX;
        end else if (v < SAT_LO) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/radial_gradient_parameter.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  pixel_t  {pixel_x, pixel_y}, Q16.16
// m_        out        m_valid / m_ready  result_t {valid_res, t_value}, Q16.16
// cfg_      in         cfg_we             cfg_index, cfg_wdata (no read-back)
//
// One item per cycle sustained while m_ready stays high.
// Latency is set by the 32-step square root and the 33-step divider in the back end.
// Reset (aresetn low, synchronous) empties all pipelines and the queue and loads
// register defaults; the quad coefficient and t span are then derived through registers.
// A stalled m_ valid freezes the back end only; the front keeps taking items
// until the four-entry queue fills, then s_ready drops.

`default_nettype none

module radial_gradient_parameter import rgp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  pixel_t      s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_data,

    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    cfg_t cfg;
    logic push, pop, q_not_full, q_empty;
    job_t push_job, q_head;

    // register file plus precomputed A and t span
    rgp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // front: translate, form B and C, discriminant, classify
    // stalls as a whole only when the queue is full
    rgp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (q_not_full),
        .s_valid  (s_valid),
        .s_data   (s_data),
        .cfg      (cfg),
        .push     (push),
        .push_job (push_job)
    );

    assign s_ready = q_not_full;

    // decoupling queue between front and back
    rgp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .not_full (q_not_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // back: square root, two-lane divide, root test, output register
    rgp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .cfg     (cfg),
        .pop     (pop),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[rtl/rgp_cfg.sv]
`default_nettype none

module rgp_cfg import rgp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    output cfg_t        cfg
);

    logic [63:0]        center_reg;
    logic [30:0]        r0_reg;
    logic signed [31:0] dx_reg, dy_reg, dr_reg, t_start_reg, t_end_reg;
    logic [1:0]         ext_reg;

    logic signed [63:0]       p_dx, p_dy, p_dr;
    logic signed [PROD_W-1:0] sq_dx_reg, sq_dy_reg, sq_dr_reg;
    logic signed [PROD_W+1:0] a_sum;
    logic signed [31:0]       a_reg;
    logic signed [32:0]       t_span_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg  <= '0;
            r0_reg      <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            dr_reg      <= '0;
            t_start_reg <= '0;
            t_end_reg   <= T_END_RESET;
            ext_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_XY:    center_reg  <= cfg_wdata;
                REG_START_RADIUS: r0_reg      <= cfg_wdata[30:0];
                REG_DELTA_X:      dx_reg      <= cfg_wdata[31:0];
                REG_DELTA_Y:      dy_reg      <= cfg_wdata[31:0];
                REG_DELTA_RADIUS: dr_reg      <= cfg_wdata[31:0];
                REG_T_START:      t_start_reg <= cfg_wdata[31:0];
                REG_T_END:        t_end_reg   <= cfg_wdata[31:0];
                REG_EXTEND_MODE:  ext_reg     <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // A = dx^2 + dy^2 - dr^2, two stages behind the registers
    assign p_dx  = dx_reg * dx_reg;
    assign p_dy  = dy_reg * dy_reg;
    assign p_dr  = dr_reg * dr_reg;
    assign a_sum = (PROD_W+2)'(sq_dx_reg) + (PROD_W+2)'(sq_dy_reg)
                 - (PROD_W+2)'(sq_dr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_dx_reg  <= '0;
            sq_dy_reg  <= '0;
            sq_dr_reg  <= '0;
            a_reg      <= '0;
            t_span_reg <= '0;
        end else begin
            sq_dx_reg  <= p_dx[63:FRAC_BITS];
            sq_dy_reg  <= p_dy[63:FRAC_BITS];
            sq_dr_reg  <= p_dr[63:FRAC_BITS];
            a_reg      <= sat32(64'(a_sum));
            t_span_reg <= 33'(t_end_reg) - 33'(t_start_reg);
        end
    end

    assign cfg.center_x     = center_reg[63:32];
    assign cfg.center_y     = center_reg[31:0];
    assign cfg.start_radius = r0_reg;
    assign cfg.delta_x      = dx_reg;
    assign cfg.delta_y      = dy_reg;
    assign cfg.delta_radius = dr_reg;
    assign cfg.t_start      = t_start_reg;
    assign cfg.t_end        = t_end_reg;
    assign cfg.extend_mode  = ext_reg;
    assign cfg.quad         = a_reg;
    assign cfg.t_span       = t_span_reg;

endmodule

`default_nettype wire

[rtl/rgp_front.sv]
`default_nettype none

module rgp_front import rgp_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   s_valid,
    input  pixel_t s_data,
    input  cfg_t   cfg,
    output logic   push,
    output job_t   push_job
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [31:0] xs_reg, ys_reg;
    logic signed [31:0] r0_s;
    logic signed [63:0] p_bx, p_by, p_br, p_cx, p_cy, p_cr, p_bb, p_ac;
    logic signed [PROD_W-1:0] bx_reg, by_reg, br_reg, cx_reg, cy_reg, cr_reg;
    logic signed [31:0] b3_reg, c3_reg, b4_reg, c4_reg;
    logic signed [PROD_W-1:0] bb_reg, ac_reg;
    logic lin_reg;
    logic signed [PROD_W:0] d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign r0_s = $signed({1'b0, cfg.start_radius});
    assign p_bx = xs_reg * cfg.delta_x;
    assign p_by = ys_reg * cfg.delta_y;
    assign p_br = r0_s * cfg.delta_radius;
    assign p_cx = xs_reg * xs_reg;
    assign p_cy = ys_reg * ys_reg;
    assign p_cr = r0_s * r0_s;
    assign p_bb = b3_reg * b3_reg;
    assign p_ac = cfg.quad * c3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xs_reg  <= sat32(64'(s_data.pixel_x) - 64'(cfg.center_x));
            ys_reg  <= sat32(64'(s_data.pixel_y) - 64'(cfg.center_y));
            bx_reg  <= p_bx[63:FRAC_BITS];
            by_reg  <= p_by[63:FRAC_BITS];
            br_reg  <= p_br[63:FRAC_BITS];
            cx_reg  <= p_cx[63:FRAC_BITS];
            cy_reg  <= p_cy[63:FRAC_BITS];
            cr_reg  <= p_cr[63:FRAC_BITS];
            b3_reg  <= sat32(64'(bx_reg) + 64'(by_reg) + 64'(br_reg));
            c3_reg  <= sat32(64'(cx_reg) + 64'(cy_reg) - 64'(cr_reg));
            bb_reg  <= p_bb[63:FRAC_BITS];
            ac_reg  <= p_ac[63:FRAC_BITS];
            b4_reg  <= b3_reg;
            c4_reg  <= c3_reg;
            lin_reg <= (cfg.quad <= EPS_Q) && (cfg.quad >= -EPS_Q);
        end
    end

    // discriminant and classification
    assign d = (PROD_W+1)'(bb_reg) - (PROD_W+1)'(ac_reg);

    always_comb begin
        push_job.lin  = lin_reg;
        push_job.b    = b4_reg;
        push_job.c    = c4_reg;
        push_job.dead = lin_reg ? ((b4_reg <= EPS_Q) && (b4_reg >= -EPS_Q)) : d[PROD_W];
        push_job.disc = (lin_reg || d[PROD_W]) ? '0 : d[PROD_W-1:0];
    end

    assign push = v4_reg && en;

endmodule

`default_nettype wire

[rtl/rgp_queue.sv]
`default_nettype none

module rgp_queue import rgp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic not_full,
    output logic empty,
    output job_t head
);

    job_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_job;
    end

    assign not_full = count_reg != (QAW+1)'(QDEPTH);
    assign empty    = count_reg == '0;
    assign head     = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[rtl/rgp_back.sv]
`default_nettype none

module rgp_back import rgp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_empty,
    input  job_t    q_head,
    input  cfg_t    cfg,
    output logic    pop,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t m_data
);

    function automatic logic [DIVW-1:0] mag(input logic signed [DIVW-1:0] v);
        return v[DIVW-1] ? DIVW'(-v) : DIVW'(v);
    endfunction

    function automatic logic signed [31:0] q_sat(input logic [DIV_STEPS-1:0] q,
                                                 input logic neg, input logic ovf);
        logic signed [31:0] r;
        if (!neg) begin
            r = (ovf || q > DIV_STEPS'(S32_MAX)) ? S32_MAX : q[31:0];
        end else begin
            r = (ovf || q > {1'b0, S32_MIN}) ? S32_MIN : -$signed(q[31:0]);
        end
        return r;
    endfunction

    logic en;

    // square-root pipeline
    logic                sq_v_reg    [SQRT_STEPS+1];
    job_t                sq_job_reg  [SQRT_STEPS+1];
    logic [63:0]         sq_rad_reg  [SQRT_STEPS+1];
    logic [SQ_REM_W-1:0] sq_rem_reg  [SQRT_STEPS+1];
    logic [31:0]         sq_root_reg [SQRT_STEPS+1];

    // divider pipeline, two lanes
    logic                    dv_v_reg    [DIV_STEPS+1];
    logic                    dv_dead_reg [DIV_STEPS+1];
    logic [DIVW-1:0]         dv_den_reg  [DIV_STEPS+1];
    logic                    dv_neg0_reg [DIV_STEPS+1];
    logic                    dv_neg1_reg [DIV_STEPS+1];
    logic                    dv_ovf0_reg [DIV_STEPS+1];
    logic                    dv_ovf1_reg [DIV_STEPS+1];
    logic [DREM_W-1:0]       dv_rem0_reg [DIV_STEPS+1];
    logic [DREM_W-1:0]       dv_rem1_reg [DIV_STEPS+1];
    logic [DIV_STEPS-1:0]    dv_q0_reg   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0]    dv_q1_reg   [DIV_STEPS+1];

    // setup for the divider
    logic signed [31:0]     root_s;
    logic signed [DIVW-1:0] n0, n1, den;
    logic [DIVW-1:0]        mn0, mn1, mden;

    // root test stage
    logic                     mv_reg, mdead_reg;
    logic signed [31:0]       s0_reg, s1_reg, s0, s1;
    logic signed [63:0]       p_r0, p_r1;
    logic signed [64:0]       p_t0, p_t1;
    logic signed [PROD_W-1:0] pr0_reg, pr1_reg;
    logic signed [PROD_W:0]   pt0_reg, pt1_reg;
    logic signed [PROD_W+1:0] rad0, rad1;
    logic in0, in1, qual0, qual1, ok;
    logic signed [31:0] tv0, tv1, t_sel;

    logic    out_v_reg;
    result_t out_reg;

    assign en  = !out_v_reg || m_ready;
    assign pop = en && !q_empty;

    // ---- load from queue ----
    always_ff @(posedge aclk) begin
        if (!aresetn) sq_v_reg[0] <= 1'b0;
        else if (en)  sq_v_reg[0] <= !q_empty;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_job_reg[0]  <= q_head;
            sq_rad_reg[0]  <= {q_head.disc, {FRAC_BITS{1'b0}}};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // ---- integer square root, one bit per step ----
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [SQ_REM_W+1:0] raw, trial;
        assign raw   = {sq_rem_reg[k], sq_rad_reg[k][63:62]};
        assign trial = {{(SQ_REM_W-32){1'b0}}, sq_root_reg[k], 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) sq_v_reg[k+1] <= 1'b0;
            else if (en)  sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_job_reg[k+1] <= sq_job_reg[k];
                sq_rad_reg[k+1] <= {sq_rad_reg[k][61:0], 2'b00};
                if (raw >= trial) begin
                    sq_rem_reg[k+1]  <= SQ_REM_W'(raw - trial);
                    sq_root_reg[k+1] <= {sq_root_reg[k][30:0], 1'b1};
                end else begin
                    sq_rem_reg[k+1]  <= raw[SQ_REM_W-1:0];
                    sq_root_reg[k+1] <= {sq_root_reg[k][30:0], 1'b0};
                end
            end
        end
    end

    // ---- divider setup: numerators, divisor, signs, overflow ----
    assign root_s = sq_root_reg[SQRT_STEPS][31] ? S32_MAX : sq_root_reg[SQRT_STEPS];

    always_comb begin
        if (sq_job_reg[SQRT_STEPS].lin) begin
            n0  = DIVW'(sq_job_reg[SQRT_STEPS].c);
            n1  = DIVW'(sq_job_reg[SQRT_STEPS].c);
            den = DIVW'(sq_job_reg[SQRT_STEPS].b) <<< 1;
        end else begin
            n0  = DIVW'(sq_job_reg[SQRT_STEPS].b) + DIVW'(root_s);
            n1  = DIVW'(sq_job_reg[SQRT_STEPS].b) - DIVW'(root_s);
            den = DIVW'(cfg.quad);
        end
        mn0  = mag(n0);
        mn1  = mag(n1);
        mden = mag(den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) dv_v_reg[0] <= 1'b0;
        else if (en)  dv_v_reg[0] <= sq_v_reg[SQRT_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_dead_reg[0] <= sq_job_reg[SQRT_STEPS].dead;
            dv_den_reg[0]  <= mden;
            dv_neg0_reg[0] <= n0[DIVW-1] ^ den[DIVW-1];
            dv_neg1_reg[0] <= n1[DIVW-1] ^ den[DIVW-1];
            dv_ovf0_reg[0] <= (DREM_W+1)'(mn0) >=
                              ((DREM_W+1)'(mden) << (DIV_STEPS - FRAC_BITS));
            dv_ovf1_reg[0] <= (DREM_W+1)'(mn1) >=
                              ((DREM_W+1)'(mden) << (DIV_STEPS - FRAC_BITS));
            dv_rem0_reg[0] <= DREM_W'(mn0) << FRAC_BITS;
            dv_rem1_reg[0] <= DREM_W'(mn1) << FRAC_BITS;
            dv_q0_reg[0]   <= '0;
            dv_q1_reg[0]   <= '0;
        end
    end

    // ---- restoring division, one quotient bit per step ----
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - k;
        logic [DTRIAL_W-1:0] trial;
        logic                ge0, ge1;
        assign trial = DTRIAL_W'(dv_den_reg[k]) << SH;
        assign ge0   = DTRIAL_W'(dv_rem0_reg[k]) >= trial;
        assign ge1   = DTRIAL_W'(dv_rem1_reg[k]) >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) dv_v_reg[k+1] <= 1'b0;
            else if (en)  dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_dead_reg[k+1] <= dv_dead_reg[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_neg0_reg[k+1] <= dv_neg0_reg[k];
                dv_neg1_reg[k+1] <= dv_neg1_reg[k];
                dv_ovf0_reg[k+1] <= dv_ovf0_reg[k];
                dv_ovf1_reg[k+1] <= dv_ovf1_reg[k];
                dv_rem0_reg[k+1] <= ge0 ? dv_rem0_reg[k] - trial[DREM_W-1:0]
                                        : dv_rem0_reg[k];
                dv_rem1_reg[k+1] <= ge1 ? dv_rem1_reg[k] - trial[DREM_W-1:0]
                                        : dv_rem1_reg[k];
                dv_q0_reg[k+1]   <= {dv_q0_reg[k][DIV_STEPS-2:0], ge0};
                dv_q1_reg[k+1]   <= {dv_q1_reg[k][DIV_STEPS-2:0], ge1};
            end
        end
    end

    // ---- root test products ----
    assign s0   = q_sat(dv_q0_reg[DIV_STEPS], dv_neg0_reg[DIV_STEPS], dv_ovf0_reg[DIV_STEPS]);
    assign s1   = q_sat(dv_q1_reg[DIV_STEPS], dv_neg1_reg[DIV_STEPS], dv_ovf1_reg[DIV_STEPS]);
    assign p_r0 = s0 * cfg.delta_radius;
    assign p_r1 = s1 * cfg.delta_radius;
    assign p_t0 = cfg.t_span * s0;
    assign p_t1 = cfg.t_span * s1;

    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (en)  mv_reg <= dv_v_reg[DIV_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mdead_reg <= dv_dead_reg[DIV_STEPS];
            s0_reg    <= s0;
            s1_reg    <= s1;
            pr0_reg   <= p_r0[63:FRAC_BITS];
            pr1_reg   <= p_r1[63:FRAC_BITS];
            pt0_reg   <= p_t0[64:FRAC_BITS];
            pt1_reg   <= p_t1[64:FRAC_BITS];
        end
    end

    // ---- qualify candidates, the (B + root) / A root first ----
    assign rad0 = (PROD_W+2)'($signed({1'b0, cfg.start_radius})) + (PROD_W+2)'(pr0_reg);
    assign rad1 = (PROD_W+2)'($signed({1'b0, cfg.start_radius})) + (PROD_W+2)'(pr1_reg);
    assign in0  = !s0_reg[31] && (33'(s0_reg) <= ONE_Q);
    assign in1  = !s1_reg[31] && (33'(s1_reg) <= ONE_Q);

    assign qual0 = !rad0[PROD_W+1] && (in0 || (s0_reg[31] && cfg.extend_mode[0])
                   || (33'(s0_reg) > ONE_Q && cfg.extend_mode[1]));
    assign qual1 = !rad1[PROD_W+1] && (in1 || (s1_reg[31] && cfg.extend_mode[0])
                   || (33'(s1_reg) > ONE_Q && cfg.extend_mode[1]));

    assign tv0 = in0 ? sat32(64'(cfg.t_start) + 64'(pt0_reg))
                     : (s0_reg[31] ? cfg.t_start : cfg.t_end);
    assign tv1 = in1 ? sat32(64'(cfg.t_start) + 64'(pt1_reg))
                     : (s1_reg[31] ? cfg.t_start : cfg.t_end);

    assign ok = !mdead_reg && (qual0 || qual1);

    always_comb begin
        priority if (!ok) begin
            t_sel = '0;
        end else if (qual0) begin
            t_sel = tv0;
        end else begin
            t_sel = tv1;
        end
    end

    // ---- output register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en)  out_v_reg <= mv_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.valid_res <= ok;
            out_reg.t_value   <= t_sel;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

[rtl/rgp_checker.sv]
`default_nettype none

module rgp_checker import rgp_pkg::*; (
    input logic    aclk,
    input logic    aresetn,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_data
);

    // result held until taken
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before the item was taken");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("m_data changed while stalled");

    // reset empties the output and the queue
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("s_ready low right after reset");

    // no solution reports zero
    a_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |-> m_data.t_value == '0)
        else $error("t_value nonzero on an invalid item");

endmodule

bind radial_gradient_parameter rgp_checker u_rgp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import rgp_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    pixel_t      s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    result_t     m_data;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    always #4 aclk = ~aclk;

    radial_gradient_parameter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 100;

    // ------------------------------------------------------------------
    // Shading setup as the block should hold it
    // ------------------------------------------------------------------
    longint cf_cx, cf_cy, cf_r0, cf_dx, cf_dy, cf_dr, cf_t0, cf_t1, cf_quad, cf_span;
    logic [1:0] cf_ext;

    pixel_t  pixel_q[$];        // items waiting for the driver
    result_t shade_q[$];        // predicted results, oldest first
    int      errors = 0;
    int      checked = 0;
    int      n_valid = 0;
    int      n_phases = 0;
    int      cycles = 0;
    bit      steady = 1'b0;     // phase without idle or stall gaps

    function automatic longint clamp32(longint v);
        if (v > longint'(S32_MAX)) return longint'(S32_MAX);
        if (v < longint'(S32_MIN)) return longint'(S32_MIN);
        return v;
    endfunction

    // arithmetic shift floors, as the block does
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint sext32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic void refresh_derived();
        cf_quad = clamp32(qmul(cf_dx, cf_dx) + qmul(cf_dy, cf_dy) - qmul(cf_dr, cf_dr));
        cf_span = cf_t1 - cf_t0;
    endfunction

    function automatic void setup_reset();
        cf_cx = 0; cf_cy = 0; cf_r0 = 0;
        cf_dx = 0; cf_dy = 0; cf_dr = 0;
        cf_t0 = 0; cf_t1 = 65536; cf_ext = 2'b00;
        refresh_derived();
    endfunction

    function automatic void setup_write(logic [3:0] idx, logic [63:0] v);
        case (idx)
            REG_CENTER_XY: begin
                cf_cx = sext32(v[63:32]);
                cf_cy = sext32(v[31:0]);
            end
            REG_START_RADIUS: cf_r0 = longint'(v[30:0]);
            REG_DELTA_X:      cf_dx = sext32(v[31:0]);
            REG_DELTA_Y:      cf_dy = sext32(v[31:0]);
            REG_DELTA_RADIUS: cf_dr = sext32(v[31:0]);
            REG_T_START:      cf_t0 = sext32(v[31:0]);
            REG_T_END:        cf_t1 = sext32(v[31:0]);
            REG_EXTEND_MODE:  cf_ext = v[1:0];
            default: return;    // unmapped index: no effect
        endcase
        refresh_derived();
    endfunction

    // does root s give a usable parameter; t gets it if so
    function automatic bit root_usable(longint s, output longint t);
        t = 0;
        if (cf_r0 + qmul(s, cf_dr) < 0) return 1'b0;
        if (s >= 0 && s <= ONE) begin
            t = clamp32(cf_t0 + ((cf_span * s) >>> FRAC_BITS));
            return 1'b1;
        end
        if (s < 0 && cf_ext[0]) begin
            t = cf_t0;
            return 1'b1;
        end
        if (s > ONE && cf_ext[1]) begin
            t = cf_t1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t shade_pixel(pixel_t p);
        longint xs, ys, a, b, c, d, root, s0, s1, t;
        bit ok;
        result_t r;
        xs = clamp32(longint'(p.pixel_x) - cf_cx);
        ys = clamp32(longint'(p.pixel_y) - cf_cy);
        a = cf_quad;
        b = clamp32(qmul(xs, cf_dx) + qmul(ys, cf_dy) + qmul(cf_r0, cf_dr));
        c = clamp32(qmul(xs, xs) + qmul(ys, ys) - qmul(cf_r0, cf_r0));
        ok = 1'b0;
        t = 0;
        if (a <= EPSILON && a >= -EPSILON) begin
            // linear case; flat B means no solution at all
            if (b > EPSILON || b < -EPSILON) begin
                s0 = clamp32((c * ONE) / (2 * b));
                ok = root_usable(s0, t);
            end
        end else begin
            d = qmul(b, b) - qmul(a, c);
            if (d >= 0) begin
                root = clamp32(longint'(int_sqrt(longint'(d) << FRAC_BITS)));
                s0 = clamp32(((b + root) * ONE) / a);
                s1 = clamp32(((b - root) * ONE) / a);
                ok = root_usable(s0, t);
                if (!ok) ok = root_usable(s1, t);
            end
        end
        r.valid_res = ok;
        r.t_value = ok ? 32'(t) : 32'sd0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one item in flight on s_, random gap before each
    // ------------------------------------------------------------------
    int send_gap = 0;
    always @(posedge aclk) begin
        logic   nxt_valid;
        pixel_t nxt_data;
        nxt_valid = s_valid;
        nxt_data = s_data;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                shade_q.push_back(shade_pixel(s_data));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pixel_q.size() > 0) begin
                    nxt_data = pixel_q.pop_front();
                    nxt_valid = 1'b1;
                    send_gap <= steady ? 0 : $urandom_range(0, 7);
                end
            end
        end
        s_valid <= nxt_valid;
        s_data <= nxt_data;
    end

    // ------------------------------------------------------------------
    // Monitor: random stalls on m_ready, in-order compare
    // ------------------------------------------------------------------
    int stall = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                checked++;
                if (shade_q.size() == 0) begin
                    report_mismatch("result with nothing pending, t_value",
                                    m_data.t_value, 0);
                end else begin
                    want = shade_q.pop_front();
                    if (want.valid_res) n_valid++;
                    if (m_data.valid_res !== want.valid_res)
                        report_mismatch("valid_res", m_data.valid_res, want.valid_res);
                    if (m_data.t_value !== want.t_value)
                        report_mismatch("t_value", m_data.t_value, want.t_value);
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                m_ready <= 1'b0;
            end else begin
                stall <= steady ? 0 : $urandom_range(0, 7);
                m_ready <= 1'b1;
            end
        end
    end

    // run guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic reg_write(logic [3:0] idx, logic [63:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        setup_write(idx, v);
    endtask

    task automatic load_setup(longint cx, longint cy, longint r0, longint dx, longint dy,
                              longint dr, longint t0, longint t1, logic [1:0] ext);
        reg_write(REG_CENTER_XY, {32'(cx), 32'(cy)});
        reg_write(REG_START_RADIUS, 64'(r0));
        reg_write(REG_DELTA_X, 64'(dx));
        reg_write(REG_DELTA_Y, 64'(dy));
        reg_write(REG_DELTA_RADIUS, 64'(dr));
        reg_write(REG_T_START, 64'(t0));
        reg_write(REG_T_END, 64'(t1));
        reg_write(REG_EXTEND_MODE, 64'(ext));
        @(posedge aclk);
        cfg_we <= 1'b0;
        repeat (4) @(posedge aclk);     // derived terms settle
    endtask

    // block idle: queue drained, nothing in flight, nothing pending
    // sampled mid-cycle so the driver's updates have settled
    task automatic wait_idle();
        @(negedge aclk);
        while (pixel_q.size() > 0 || s_valid || shade_q.size() > 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic pixel_t near_pixel(longint span);
        pixel_t p;
        p.pixel_x = 32'(cf_cx + $signed($urandom_range(0, 2 * span)) - span);
        p.pixel_y = 32'(cf_cy + $signed($urandom_range(0, 2 * span)) - span);
        return p;
    endfunction

    function automatic pixel_t any_pixel();
        pixel_t p;
        p.pixel_x = $urandom;
        p.pixel_y = $urandom;
        return p;
    endfunction

    function automatic longint small_q(int units);
        return longint'($signed($urandom_range(0, 2 * units * 65536))) - units * 65536;
    endfunction

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8) pixel_q.push_back(near_pixel(8 * 65536));
            else pixel_q.push_back(any_pixel());
        end
    endtask

    initial begin
        pixel_t p;
        setup_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // Defaults straight after reset: A = 0, B = 0 so nothing qualifies
        p.pixel_x = 32'sd65536; p.pixel_y = 32'sd0;
        pixel_q.push_back(p);
        random_batch(6);
        wait_idle();

        // Directed: well-conditioned cone, full extend, field extremes
        n_phases++;
        load_setup(0, 0, 65536, 2 * 65536, 0, 65536, 0, 65536, 2'b11);
        pixel_q.push_back('{32'sd0, 32'sd0});
        pixel_q.push_back('{S32_MAX, S32_MAX});
        pixel_q.push_back('{S32_MIN, S32_MIN});
        pixel_q.push_back('{S32_MAX, S32_MIN});
        pixel_q.push_back('{S32_MIN, S32_MAX});
        pixel_q.push_back('{32'sd65536, 32'sd0});
        pixel_q.push_back('{32'sd131072, 32'sd0});
        pixel_q.push_back('{-32'sd65536, 32'sd0});
        pixel_q.push_back('{32'sd0, 32'sd65536});
        pixel_q.push_back('{32'sd196608, 32'sd32768});
        pixel_q.push_back('{32'sd0, 32'sd2000000});   // negative discriminant
        wait_idle();
        // Extend off: roots outside [0,1] drop out
        reg_write(REG_EXTEND_MODE, 64'd0);
        reg_write(REG_CENTER_XY + 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);   // unmapped index
        reg_write(4'd15, 64'h1234_5678_9ABC_DEF0);
        @(posedge aclk); cfg_we <= 1'b0;
        repeat (4) @(posedge aclk);
        pixel_q.push_back('{-32'sd65536, 32'sd0});
        pixel_q.push_back('{32'sd196608, 32'sd0});
        pixel_q.push_back('{32'sd32768, 32'sd0});
        wait_idle();
        // Linear case with B mostly nonzero, then degenerate B = 0
        load_setup(0, 0, 65536, 65536, 0, 65536, 0, 65536, 2'b01);
        pixel_q.push_back('{32'sd65536, 32'sd0});
        pixel_q.push_back('{-32'sd65536, 32'sd0});
        pixel_q.push_back('{32'sd327680, 32'sd0});
        pixel_q.push_back('{-32'sd131072, 32'sd65536});  // B = -1.0
        wait_idle();
        load_setup(0, 0, 0, 0, 0, 0, 0, 65536, 2'b11);
        pixel_q.push_back('{32'sd65536, 32'sd65536});
        pixel_q.push_back('{32'sd0, 32'sd0});
        wait_idle();

        // Register extremes
        n_phases++;
        load_setup(longint'(S32_MAX), longint'(S32_MAX), 64'h7FFF_FFFF, longint'(S32_MAX),
                   longint'(S32_MAX), longint'(S32_MAX), longint'(S32_MAX),
                   longint'(S32_MAX), 2'b11);
        random_batch(40);
        wait_idle();
        n_phases++;
        load_setup(longint'(S32_MIN), longint'(S32_MIN), 0, longint'(S32_MIN),
                   longint'(S32_MIN), longint'(S32_MIN), longint'(S32_MIN),
                   longint'(S32_MAX), 2'b10);
        random_batch(40);
        wait_idle();

        // Random setups: mostly small geometry, one in four fully random
        for (int ph = 0; ph < 10; ph++) begin
            n_phases++;
            steady = (ph % 4 == 3);
            if (ph % 4 == 2)
                load_setup($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, 2'($urandom));
            else
                load_setup(small_q(4), small_q(4), $urandom_range(0, 4 * 65536),
                           small_q(6), small_q(6), small_q(3), small_q(2), small_q(2),
                           2'($urandom));
            random_batch(80);
            // sender holds off until every result is back, then resumes
            wait_idle();
            random_batch(80);
            wait_idle();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d setups, %0d results checked, %0d with a usable root",
                 n_phases, checked, n_valid);
        if (errors == 0 && shade_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (shade_q.size() != 0)
                $display("%0d expected results never arrived", shade_q.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
